// ----- rtl/core/salc_pkg.sv -----
`timescale 1ns / 1ps
package salc_pkg;
    localparam int MaxSetBits = 6;
    localparam int MaxWays = 8;
    localparam int AddrBits = 64;
    localparam int NumSets = 1 << MaxSetBits;
    localparam int SetW = MaxSetBits;
    localparam int WayW = $clog2(MaxWays);
    localparam int RankW = WayW;
    localparam int CntW = 32;

    localparam logic [1:0] FuncModify = 2'd2;

    localparam logic [1:0] RegSetBits = 2'd0;
    localparam logic [1:0] RegBlockBits = 2'd1;
    localparam logic [1:0] RegWays = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [63:0] address;
    } t_req;

    typedef struct packed {
        logic hit;
        logic miss;
        logic evicted;
        logic [CntW-1:0] hits_total;
        logic [CntW-1:0] misses_total;
        logic [CntW-1:0] evictions_total;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;
endpackage

// ----- rtl/core/set_assoc_lru_cache_model_unit.sv -----
`timescale 1ns / 1ps
// Set-associative cache simulator with LRU replacement. Each request is one
// memory access; one response follows with hit, miss and eviction flags and
// running 32-bit totals. A request is handled by reading the whole set
// (tags, valid bits and age ranks of all eight ways, one row of each
// memory) and then comparing, picking a way and writing the rows back. The
// next request is taken in the cycle after the write-back at the earliest,
// and only while the response register is free.
// After reset a clearing pass walks the 64 rows of the line-state memory,
// one row per cycle, during which no request is accepted; configuration
// writes are taken at any time.
module set_assoc_lru_cache_model_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [5:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  salc_pkg::t_req       i_req,
    output logic                 o_valid,
    input  logic                 i_stall,
    output salc_pkg::t_rsp       o_rsp
);
    import salc_pkg::*;

    // Configuration registers.
    logic [2:0] r_set_bits;
    logic [5:0] r_block_bits;
    logic [3:0] r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 3'd4;
            r_block_bits <= 6'd4;
            r_ways       <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegSetBits:   r_set_bits   <= i_cfg_data[2:0];
                RegBlockBits: r_block_bits <= i_cfg_data;
                RegWays:      r_ways       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Tags live in one memory, valid bits and ranks in another; each row is
    // a whole set. Tags need no clearing since they are only compared when valid.
    logic [MaxWays-1:0][AddrBits-1:0]  tag_mem [NumSets];
    logic [MaxWays-1:0][RankW:0]       meta_mem [NumSets];
    logic [MaxWays-1:0][AddrBits-1:0]  r_tag_rd;
    logic [MaxWays-1:0][RankW:0]       r_meta_rd;

    t_state r_state, n_state;
    logic [SetW:0] r_clr;
    logic [SetW-1:0] r_set;
    logic [AddrBits-1:0] r_tag;
    logic r_mod;
    logic [WayW:0] r_nways;
    logic r_out_v;
    t_rsp r_rsp;
    logic [CntW-1:0] r_hits, r_misses, r_evicts;

    // Address split for the incoming request.
    logic [2:0] s_eff;
    logic [AddrBits-1:0] tagset;
    logic [SetW-1:0] in_set;
    logic [AddrBits-1:0] in_tag;
    logic accept;

    always_comb begin
        s_eff  = (r_set_bits > 3'(MaxSetBits)) ? 3'(MaxSetBits) : r_set_bits;
        tagset = i_req.address >> r_block_bits;
        in_tag = tagset >> s_eff;
        in_set = tagset[SetW-1:0] & SetW'((1 << s_eff) - 1);
    end

    assign o_stall = (r_state != ST_IDLE) || (r_out_v && i_stall);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == (SetW + 1)'(NumSets - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_LOOK;
            ST_LOOK:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    // Compare, victim choice and rank update on the registered set row.
    logic [MaxWays-1:0] vld, match, act;
    logic [MaxWays-1:0][RankW-1:0] rank;
    logic hit, has_free, evict;
    logic [WayW-1:0] hit_w, free_w, vic_w, pick;
    logic [RankW:0] limit;
    logic [MaxWays-1:0][RankW:0] new_meta;
    logic [MaxWays-1:0][AddrBits-1:0] new_tag;

    always_comb begin
        hit = 1'b0; has_free = 1'b0;
        hit_w = '0; free_w = '0; vic_w = '0;
        for (int w = 0; w < MaxWays; w++) begin
            act[w]   = (WayW + 1)'(w) < r_nways;
            vld[w]   = r_meta_rd[w][RankW];
            rank[w]  = r_meta_rd[w][RankW-1:0];
            match[w] = act[w] && vld[w] && (r_tag_rd[w] == r_tag);
        end
        for (int w = MaxWays - 1; w >= 0; w--) begin
            if (match[w]) begin hit = 1'b1; hit_w = WayW'(w); end
            if (act[w] && !vld[w]) begin has_free = 1'b1; free_w = WayW'(w); end
        end
        for (int w = 1; w < MaxWays; w++) begin
            if (act[w] && rank[w] > rank[vic_w]) vic_w = WayW'(w);
        end
        evict = !hit && !has_free;
        pick  = hit ? hit_w : (has_free ? free_w : vic_w);
        limit = (hit || evict) ? {1'b0, rank[pick]} : {1'b1, {RankW{1'b0}}};
        new_meta = r_meta_rd;
        new_tag  = r_tag_rd;
        for (int w = 0; w < MaxWays; w++) begin
            if (act[w] && WayW'(w) != pick && vld[w]
                    && {1'b0, rank[w]} < limit && rank[w] != RankW'(MaxWays - 1))
                new_meta[w] = {1'b1, rank[w] + 1'b1};
        end
        new_meta[pick] = {1'b1, {RankW{1'b0}}};
        new_tag[pick]  = r_tag;
    end

    // Memories: read in the accept cycle, written back in the look cycle (tags only on a miss).
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR)
            meta_mem[r_clr[SetW-1:0]] <= '0;
        else if (r_state == ST_LOOK)
            meta_mem[r_set] <= new_meta;
        if (r_state == ST_LOOK && !hit)
            tag_mem[r_set] <= new_tag;
        r_meta_rd <= meta_mem[in_set];
        r_tag_rd  <= tag_mem[in_set];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set   <= in_set;
            r_tag   <= in_tag;
            r_mod   <= i_req.func == FuncModify;
            r_nways <= (r_ways == 4'd0) ? (WayW + 1)'(1)
                     : (r_ways > 4'(MaxWays)) ? (WayW + 1)'(MaxWays) : r_ways[WayW:0];
        end
    end

    // Counters and the response register.
    logic [CntW-1:0] n_hits, n_misses, n_evicts;
    always_comb begin
        n_hits   = r_hits + CntW'(hit) + CntW'(r_mod);
        n_misses = r_misses + CntW'(!hit);
        n_evicts = r_evicts + CntW'(evict);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0; r_misses <= '0; r_evicts <= '0; r_out_v <= 1'b0;
        end else begin
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            if (r_state == ST_LOOK) begin
                r_hits   <= n_hits;
                r_misses <= n_misses;
                r_evicts <= n_evicts;
                r_out_v  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK)
            r_rsp <= '{hit: hit, miss: !hit, evicted: evict, hits_total: n_hits,
                       misses_total: n_misses, evictions_total: n_evicts};
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_rsp;

    // A response appears in the cycle after the look cycle.
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> o_valid)
        else $error("response missing after lookup");
    // A miss and a hit are never reported together.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.hit != o_rsp.miss))
        else $error("hit and miss flags inconsistent");
    // An eviction is only reported on a miss.
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.evicted) |-> o_rsp.miss)
        else $error("eviction without miss");
endmodule
